FILE: src/tilt_pkg.sv
// Package with shared types, constants and the CORDIC angle table.
package tilt_pkg;

  localparam int DefCordicSteps   = 16;
  localparam int DefAngleFracBits = 8;
  localparam int ZExtraOffset     = 205;
  localparam int TableFracBits    = 16;
  localparam int TableLen         = 24;
  localparam int AxisW            = 18;   // corrected axis width
  localparam int SqW              = 38;   // a^2 + b^2
  localparam int RadW             = 54;   // (a^2+b^2) << 16
  localparam int RootW            = 27;   // isqrt of RadW bits
  localparam int CordW            = 34;   // CORDIC x/y register width
  localparam int AngW             = 26;   // CORDIC angle accumulator
  localparam int YawW             = 40;

  localparam logic [1:0] RegXOffset = 2'd0;
  localparam logic [1:0] RegYOffset = 2'd1;
  localparam logic [1:0] RegZOffset = 2'd2;
  localparam logic [1:0] RegYawGain = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQRT,
    ST_CORDIC,
    ST_NEXT,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic capture;     // take the input word
    logic load;        // set up the angle operands (sel picks roll or pitch)
    logic sel;         // 0 = roll, 1 = pitch
    logic sqrt_step;
    logic cordic_init;
    logic cordic_step;
    logic store_angle;
    logic out_load;
  } tilt_cmd_t;

  function automatic logic [AngW-1:0] atan_entry(input logic [4:0] i);
    logic [AngW-1:0] v;
    case (i)
      5'd0:  v = 26'd2949120;
      5'd1:  v = 26'd1740967;
      5'd2:  v = 26'd919879;
      5'd3:  v = 26'd466945;
      5'd4:  v = 26'd234379;
      5'd5:  v = 26'd117304;
      5'd6:  v = 26'd58666;
      5'd7:  v = 26'd29335;
      5'd8:  v = 26'd14668;
      5'd9:  v = 26'd7334;
      5'd10: v = 26'd3667;
      5'd11: v = 26'd1833;
      5'd12: v = 26'd917;
      5'd13: v = 26'd458;
      5'd14: v = 26'd229;
      5'd15: v = 26'd115;
      5'd16: v = 26'd57;
      5'd17: v = 26'd29;
      5'd18: v = 26'd14;
      5'd19: v = 26'd7;
      5'd20: v = 26'd4;
      5'd21: v = 26'd2;
      5'd22: v = 26'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/tilt_ctrl.sv
// Controller state machine sequencing square root and CORDIC for roll then pitch.
module tilt_ctrl import tilt_pkg::*; #(
  parameter int CORDIC_STEPS = DefCordicSteps
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic      out_busy,
  output logic      in_ready,
  output tilt_cmd_t cmd,
  output logic [4:0] step
);

  localparam int SqrtSteps = RootW;
  localparam int Steps = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;

  ctrl_state_t state, state_next;
  logic [4:0]  cnt, cnt_next;
  logic        sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      sel   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      sel   <= sel_next;
    end
  end

  assign step = cnt;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    sel_next   = sel;
    cmd        = '0;
    cmd.sel    = sel;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.capture = 1'b1;
          sel_next    = 1'b0;
          state_next  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        cnt_next   = '0;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(SqrtSteps - 1)) begin
          cnt_next   = '0;
          state_next = ST_CORDIC;
          cmd.cordic_init = 1'b1;
        end
      end
      ST_CORDIC: begin
        cmd.cordic_step = 1'b1;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(Steps - 1)) begin
          state_next = ST_NEXT;
        end
      end
      ST_NEXT: begin
        cmd.store_angle = 1'b1;
        if (sel) begin
          state_next = ST_OUT;
        end else begin
          sel_next   = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: src/tilt_dp.sv
// Datapath: offsets, bit-serial square root, iterative CORDIC and yaw integrator.
module tilt_dp import tilt_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = DefAngleFracBits
) (
  input  logic              clk,
  input  logic              rst,
  input  tilt_cmd_t         cmd,
  input  logic [4:0]        step,
  input  logic [63:0]       in_word,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output logic signed [15:0] roll,
  output logic signed [15:0] pitch,
  output logic signed [31:0] yaw
);

  localparam int Drop = TableFracBits - ANGLE_FRAC_BITS;

  logic signed [15:0] x_off, y_off, z_off;
  logic [7:0]         gain;
  logic signed [AxisW-1:0] ax, ay, az;
  logic signed [15:0] gz;
  logic [YawW-1:0]    yaw_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_off <= '0;
      y_off <= '0;
      z_off <= '0;
      gain  <= 8'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        RegXOffset: x_off <= cfg_data;
        RegYOffset: y_off <= cfg_data;
        RegZOffset: z_off <= cfg_data;
        RegYawGain: gain  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input capture with offset removal.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ax <= AxisW'($signed(in_word[15:0])) - AxisW'(x_off);
      ay <= AxisW'($signed(in_word[31:16])) - AxisW'(y_off);
      az <= AxisW'($signed(in_word[47:32])) - AxisW'(ZExtraOffset) - AxisW'(z_off);
      gz <= $signed(in_word[63:48]);
    end
  end

  // Operand set-up: roll uses (ay; ax, az), pitch uses (-ax; ay, az).
  logic signed [AxisW-1:0] num_sel, a_sel;
  logic signed [AxisW:0]   num;
  logic [SqW-1:0]          sq;
  assign num_sel = cmd.sel ? ax : ay;
  assign a_sel   = cmd.sel ? ay : ax;

  logic signed [2*AxisW-1:0] a2s, b2s;
  logic [2*AxisW-1:0] a2, b2;
  assign a2s = a_sel * a_sel;
  assign b2s = az * az;
  assign a2  = $unsigned(a2s);
  assign b2  = $unsigned(b2s);
  assign sq  = SqW'(a2) + SqW'(b2);

  // Bit-serial square root: two radicand bits a step.
  logic [RadW-1:0]  rad;
  logic [RootW-1:0] root;
  logic [RootW+1:0] rem;
  logic [RootW+1:0] trial, rem_sh;
  assign rem_sh = {rem[RootW-1:0], rad[RadW-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num  <= cmd.sel ? -(AxisW+1)'(num_sel) : (AxisW+1)'(num_sel);
      rad  <= {sq, 16'd0};
      root <= '0;
      rem  <= '0;
    end else if (cmd.sqrt_step) begin
      rad <= {rad[RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[RootW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RootW-2:0], 1'b0};
      end
    end
  end

  // CORDIC vectoring, one rotation a cycle.
  logic signed [CordW-1:0] xv, yv;
  logic signed [AngW-1:0]  zv;
  logic signed [CordW-1:0] dx, dy;
  assign dx = yv >>> step;
  assign dy = xv >>> step;

  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      // The init comes with the last root step, so the final root bit is formed here.
      xv <= CordW'({root[RootW-2:0], rem_sh >= trial});
      yv <= CordW'(num) <<< 8;
      zv <= '0;
    end else if (cmd.cordic_step) begin
      if (!yv[CordW-1]) begin
        xv <= xv + dx;
        yv <= yv - dy;
        zv <= zv + $signed(atan_entry(step));
      end else begin
        xv <= xv - dx;
        yv <= yv + dy;
        zv <= zv - $signed(atan_entry(step));
      end
    end
  end

  // Round half away from zero.
  logic [AngW-1:0] mag, rmag;
  logic [15:0]     ang;
  assign mag  = zv[AngW-1] ? AngW'(-zv) : AngW'(zv);
  assign rmag = (mag + AngW'(1 << (Drop - 1))) >> Drop;
  assign ang  = (num == '0) ? 16'd0 : (zv[AngW-1] ? 16'(-rmag) : rmag[15:0]);

  logic signed [15:0] roll_hold, pitch_hold;
  always_ff @(posedge clk) begin
    if (cmd.store_angle) begin
      if (cmd.sel) pitch_hold <= ang;
      else         roll_hold  <= ang;
    end
  end

  logic signed [23:0] yinc;
  assign yinc = gz * $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_total <= '0;
    end else if (cmd.out_load) begin
      yaw_total <= yaw_total + YawW'(yinc);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      roll  <= roll_hold;
      pitch <= pitch_hold;
      yaw   <= 32'((yaw_total + YawW'(yinc)) >> 8);
    end
  end

endmodule

FILE: src/accel_tilt_angle_estimator_core.sv
// Top level of the tilt angle estimator.
// Usage: one input word on s_axis (accel x, y, z and gyro z) gives one output
// word on m_axis (roll, pitch, yaw). Calibration registers are written through
// cfg_we / cfg_index / cfg_data; the user must do so only while no word is
// in flight, as the core itself does not enforce it.
// Each angle passes through a load step, the bit-serial square root, the
// CORDIC rotations and a store step; after capture, roll then pitch is
// computed on the single shared CORDIC rotator before the result register
// loads. One word is processed at a time.
// s_axis_tready is high only while the core is idle.
// The result sits in an output register; the next input word is accepted
// while it waits, and the core holds its finished word until m_axis is free.
// Reset (synchronous, active high) clears the offsets, sets the yaw gain to
// 16 and clears the yaw accumulator.
// A stalled receiver simply holds m_axis_tvalid and m_axis_tdata steady.
module accel_tilt_angle_estimator_core import tilt_pkg::*; #(
  parameter int CORDIC_STEPS    = DefCordicSteps,
  parameter int ANGLE_FRAC_BITS = DefAngleFracBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // accel_x, accel_y, accel_z, gyro_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // roll, pitch, yaw
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  tilt_cmd_t cmd;
  logic [4:0] step;
  logic in_ready, out_busy;
  logic signed [15:0] roll, pitch;
  logic signed [31:0] yaw;

  assign s_axis_tready = in_ready;
  assign out_busy = m_axis_tvalid && !m_axis_tready;

  tilt_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst,
    .in_fire (s_axis_tvalid && in_ready),
    .out_busy,
    .in_ready,
    .cmd,
    .step
  );

  tilt_dp #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .step,
    .in_word (s_axis_tdata),
    .cfg_we, .cfg_index, .cfg_data,
    .roll, .pitch, .yaw
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {yaw, pitch, roll};

endmodule

FILE: src/tilt_checks.sv
// Port-level checker for the tilt estimator, bound to the top level.
module tilt_checks (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

endmodule

bind accel_tilt_angle_estimator_core tilt_checks u_checks (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
